>>> design/u16enc_pkg.sv
package u16enc_pkg;

    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Register indexes on the configuration port.
    localparam logic CFG_ENCODING    = 1'b0;
    localparam logic CFG_LINE_ENDING = 1'b1;

    localparam logic [1:0] ENC_UTF8     = 2'd0;
    localparam logic [1:0] ENC_UTF8_BOM = 2'd1;
    localparam logic [1:0] ENC_UTF16LE  = 2'd2;
    localparam logic [1:0] ENC_UTF16BE  = 2'd3;

    localparam logic [1:0] LE_CRLF = 2'd0;
    localparam logic [1:0] LE_LF   = 2'd1;
    localparam logic [1:0] LE_CR   = 2'd2;

    localparam logic [15:0] CHAR_NUL  = 16'h0000;
    localparam logic [15:0] CHAR_LF   = 16'h000A;
    localparam logic [15:0] CHAR_CR   = 16'h000D;
    localparam logic [15:0] CHAR_REPL = 16'hFFFD;

    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FF = 8'hFF;
    localparam logic [7:0] BOM16_FE = 8'hFE;

    // Bytes produced by one request, lowest slot first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
    } t_entry;

    // Per-text state of the front end.
    typedef struct packed {
        logic        bom_done;
        logic        after_cr;
        logic [15:0] held_high;
        logic        held_valid;
        logic        nul_seen;
    } t_state;

endpackage

>>> design/u16enc_front.sv
module u16enc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic                  i_cfg_idx,
    input  logic [1:0]            i_cfg_data,
    input  logic                  i_valid,
    input  logic [15:0]           i_code_unit,
    input  logic                  i_has_unit,
    input  logic                  i_end,
    input  logic                  i_space,
    output logic                  o_ready,
    output logic                  o_push,
    output u16enc_pkg::t_entry    o_entry,
    output u16enc_pkg::t_state    o_status
);

    typedef struct packed {
        u16enc_pkg::t_entry o;
        u16enc_pkg::t_state s;
    } t_work;

    logic [1:0]         r_encoding;
    logic [1:0]         r_line_ending;
    u16enc_pkg::t_state r_st;
    u16enc_pkg::t_state n_st;
    t_work              w;
    logic               accept;

    function automatic u16enc_pkg::t_entry put_byte(u16enc_pkg::t_entry o, logic [7:0] b);
        u16enc_pkg::t_entry r;
        r = o;
        if (r.cnt < u16enc_pkg::CNT_W'(u16enc_pkg::MAX_BYTES)) begin
            r.bytes[r.cnt] = b;
            r.cnt = r.cnt + u16enc_pkg::CNT_W'(1);
        end
        return r;
    endfunction

    function automatic u16enc_pkg::t_entry put_utf8_bmp(u16enc_pkg::t_entry o,
                                                       logic [15:0] cp);
        u16enc_pkg::t_entry r;
        r = o;
        if (cp < 16'h0080) begin
            r = put_byte(r, {1'b0, cp[6:0]});
        end else if (cp < 16'h0800) begin
            r = put_byte(r, {3'b110, cp[10:6]});
            r = put_byte(r, {2'b10, cp[5:0]});
        end else begin
            r = put_byte(r, {4'b1110, cp[15:12]});
            r = put_byte(r, {2'b10, cp[11:6]});
            r = put_byte(r, {2'b10, cp[5:0]});
        end
        return r;
    endfunction

    function automatic u16enc_pkg::t_entry put_utf8_supp(u16enc_pkg::t_entry o,
                                                        logic [20:0] cp);
        u16enc_pkg::t_entry r;
        r = o;
        r = put_byte(r, {5'b11110, cp[20:18]});
        r = put_byte(r, {2'b10, cp[17:12]});
        r = put_byte(r, {2'b10, cp[11:6]});
        r = put_byte(r, {2'b10, cp[5:0]});
        return r;
    endfunction

    function automatic u16enc_pkg::t_entry put_utf16(u16enc_pkg::t_entry o, logic [15:0] u,
                                                    logic [1:0] enc);
        u16enc_pkg::t_entry r;
        r = o;
        if (enc == u16enc_pkg::ENC_UTF16LE) begin
            r = put_byte(r, u[7:0]);
            r = put_byte(r, u[15:8]);
        end else begin
            r = put_byte(r, u[15:8]);
            r = put_byte(r, u[7:0]);
        end
        return r;
    endfunction

    function automatic t_work flush_held(t_work wi, logic [1:0] enc);
        t_work r;
        r = wi;
        if (r.s.held_valid) begin
            if (enc[1]) begin
                r.o = put_utf16(r.o, r.s.held_high, enc);
            end else begin
                r.o = put_utf8_bmp(r.o, u16enc_pkg::CHAR_REPL);
            end
            r.s.held_valid = 1'b0;
            r.s.held_high  = '0;
        end
        return r;
    endfunction

    function automatic t_work put_unit(t_work wi, logic [15:0] u, logic [1:0] enc);
        t_work       r;
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        r       = wi;
        is_high = (u[15:10] == u16enc_pkg::SURR_HIGH);
        is_low  = (u[15:10] == u16enc_pkg::SURR_LOW);
        cp      = {1'b0, r.s.held_high[9:0], u[9:0]} + 21'h010000;
        if (!r.s.nul_seen) begin
            if (enc[1]) begin
                r   = flush_held(r, enc);
                r.o = put_utf16(r.o, u, enc);
            end else if (r.s.held_valid && is_low) begin
                r.s.held_valid = 1'b0;
                r.s.held_high  = '0;
                r.o = put_utf8_supp(r.o, cp);
            end else begin
                r = flush_held(r, enc);
                if (u == u16enc_pkg::CHAR_NUL) begin
                    r.s.nul_seen = 1'b1;
                end else if (is_high) begin
                    r.s.held_high  = u;
                    r.s.held_valid = 1'b1;
                end else if (is_low) begin
                    r.o = put_utf8_bmp(r.o, u16enc_pkg::CHAR_REPL);
                end else begin
                    r.o = put_utf8_bmp(r.o, u);
                end
            end
        end
        return r;
    endfunction

    function automatic t_work put_line_break(t_work wi, logic [1:0] le, logic [1:0] enc);
        t_work r;
        r = wi;
        if (le == u16enc_pkg::LE_LF) begin
            r = put_unit(r, u16enc_pkg::CHAR_LF, enc);
        end else if (le == u16enc_pkg::LE_CR) begin
            r = put_unit(r, u16enc_pkg::CHAR_CR, enc);
        end else begin
            r = put_unit(r, u16enc_pkg::CHAR_CR, enc);
            r = put_unit(r, u16enc_pkg::CHAR_LF, enc);
        end
        return r;
    endfunction

    assign o_ready  = i_space;
    assign accept   = i_valid && i_space;
    assign o_status = r_st;

    always_comb begin
        w.o = '0;
        w.s = r_st;
        if (i_has_unit || i_end) begin
            if (!w.s.bom_done) begin
                w.s.bom_done = 1'b1;
                unique case (r_encoding)
                    u16enc_pkg::ENC_UTF8: begin
                    end
                    u16enc_pkg::ENC_UTF8_BOM: begin
                        w.o = put_byte(w.o, u16enc_pkg::BOM8_B0);
                        w.o = put_byte(w.o, u16enc_pkg::BOM8_B1);
                        w.o = put_byte(w.o, u16enc_pkg::BOM8_B2);
                    end
                    u16enc_pkg::ENC_UTF16LE: begin
                        w.o = put_byte(w.o, u16enc_pkg::BOM16_FF);
                        w.o = put_byte(w.o, u16enc_pkg::BOM16_FE);
                    end
                    default: begin
                        w.o = put_byte(w.o, u16enc_pkg::BOM16_FE);
                        w.o = put_byte(w.o, u16enc_pkg::BOM16_FF);
                    end
                endcase
            end
            // A surrogate held under a UTF-8 mode leaves first when the mode is now UTF-16.
            if (w.s.held_valid && r_encoding[1] && !w.s.nul_seen) begin
                w = flush_held(w, r_encoding);
            end
            if (i_has_unit) begin
                if (i_code_unit == u16enc_pkg::CHAR_CR) begin
                    w = put_line_break(w, r_line_ending, r_encoding);
                    w.s.after_cr = 1'b1;
                end else if (i_code_unit == u16enc_pkg::CHAR_LF) begin
                    if (!w.s.after_cr) begin
                        w = put_line_break(w, r_line_ending, r_encoding);
                    end
                    w.s.after_cr = 1'b0;
                end else begin
                    w = put_unit(w, i_code_unit, r_encoding);
                    w.s.after_cr = 1'b0;
                end
            end
            if (i_end) begin
                if (!w.s.nul_seen) begin
                    w = flush_held(w, r_encoding);
                end
                w.s = '0;
            end
        end
        n_st = accept ? w.s : r_st;
    end

    assign o_push  = accept && (w.o.cnt != '0);
    assign o_entry = w.o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= '0;
            r_encoding    <= u16enc_pkg::ENC_UTF8;
            r_line_ending <= u16enc_pkg::LE_CRLF;
        end else begin
            r_st <= n_st;
            if (i_cfg_wen && i_cfg_idx == u16enc_pkg::CFG_ENCODING) begin
                r_encoding <= i_cfg_data;
            end
            if (i_cfg_wen && i_cfg_idx == u16enc_pkg::CFG_LINE_ENDING) begin
                r_line_ending <= i_cfg_data;
            end
        end
    end

endmodule

>>> design/u16enc_fifo.sv
module u16enc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u16enc_pkg::t_entry i_entry,
    input  logic               i_pop,
    output logic               o_space,
    output logic               o_avail,
    output u16enc_pkg::t_entry o_head
);

    localparam int DEPTH = 2;

    u16enc_pkg::t_entry r_mem [DEPTH];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               do_push;
    logic               do_pop;

    assign o_space = (r_count != 2'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> design/u16enc_back.sv
module u16enc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  u16enc_pkg::t_entry i_head,
    output logic               o_pop,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast
);

    logic [u16enc_pkg::CNT_W-1:0] r_idx;
    logic [u16enc_pkg::CNT_W-1:0] n_idx;
    logic                         is_last;
    logic                         fire;

    assign is_last    = ((r_idx + u16enc_pkg::CNT_W'(1)) == i_head.cnt);
    assign o_m_tvalid = i_avail;
    assign o_m_tdata  = i_head.bytes[r_idx];
    assign o_m_tlast  = is_last;
    assign fire       = i_avail && i_m_tready;
    assign o_pop      = fire && is_last;

    always_comb begin
        n_idx = r_idx;
        if (fire) begin
            n_idx = is_last ? '0 : r_idx + u16enc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

>>> design/utf16_text_encoder_eol_normalizer.sv
// UTF-16 to byte-stream encoder with line-ending normalization.
// Slave channel: one request per UTF-16 code unit. tdata carries code_unit, tuser
// carries has_unit (0 for a request that only closes the text), tlast carries
// end_of_text. Master channel: one encoded byte per transfer, tlast on the final
// byte that a request produced. A request that produces no byte (idle, NUL-dropped,
// or a held high surrogate) gives no master transfer at all.
// The configuration port writes encoding (index 0) and line ending (index 1);
// write only while the block is idle. The front end classifies and encodes a
// request in the cycle it is accepted and stores 1 to 6 bytes in a two-entry
// queue; the bytes are registered there and are offered on the master side once
// their entry reaches the queue head. The back end sends one byte per cycle while
// the master is ready, and a request holds the output until all its bytes are
// sent (three for most BMP characters in UTF-8, two in UTF-16); the output byte
// rate, not the front end, sets throughput. Requests are taken back to back while
// a queue entry is free, so a stalled master lets up to two requests wait.
// Synchronous reset clears the queue, text state and both registers (UTF-8, CR LF).
module utf16_text_encoder_eol_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] code_unit
    input  logic        i_s_tuser,   // [0] has_unit
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast
);

    logic               push;
    logic               pop;
    logic               space;
    logic               avail;
    u16enc_pkg::t_entry entry;
    u16enc_pkg::t_entry head;
    u16enc_pkg::t_state st;

    u16enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_code_unit (i_s_tdata),
        .i_has_unit  (i_s_tuser),
        .i_end       (i_s_tlast),
        .i_space     (space),
        .o_ready     (o_s_tready),
        .o_push      (push),
        .o_entry     (entry),
        .o_status    (st)
    );

    u16enc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_space (space),
        .o_avail (avail),
        .o_head  (head)
    );

    u16enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (avail),
        .i_head     (head),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // A waiting high surrogate is always a real high surrogate.
    a_held_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.held_valid |-> (st.held_high[15:10] == u16enc_pkg::SURR_HIGH))
        else $error("held unit is not a high surrogate");

    // Nothing is held once a NUL has ended the UTF-8 output.
    a_no_held_after_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.nul_seen |-> !st.held_valid)
        else $error("surrogate held after NUL");

    // The end of a text returns the text state to its reset value.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast)
        |=> (!st.bom_done && !st.after_cr && !st.held_valid && !st.nul_seen))
        else $error("text state not cleared at end of text");

endmodule
